FILE: rtl/kwoc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kwoc_pkg;

    // Window and counter sizing
    localparam int MAX_K          = 8;
    localparam int COUNT_BITS     = 16;
    localparam int NUM_OPS        = 9;
    localparam int ROW_BITS       = $clog2(MAX_K);
    localparam int FILL_BITS      = $clog2(MAX_K + 1);
    localparam int TOTAL_BITS     = 20;

    // Field widths of the two channels and the length register
    localparam int OP_BITS        = 4;
    localparam int BASE_BITS      = 2;
    localparam int LEN_BITS       = 4;
    localparam int INDEX_BITS     = 16;
    localparam int OUT_TOTAL_BITS = 19;

    // Window length after reset
    localparam logic [LEN_BITS-1:0] LEN_RESET = 4'd6;

    // Step held in the input register
    typedef struct packed {
        logic [OP_BITS-1:0]   op_code;
        logic                 read_move;
        logic [BASE_BITS-1:0] base;
        logic                 base_ok;
    } t_step;

    typedef logic [OUT_TOTAL_BITS-1:0] t_out_total;

    // Result held in the output register
    typedef struct packed {
        logic                  window_full;
        logic [INDEX_BITS-1:0] window_code;
        t_out_total [NUM_OPS-1:0] total;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/kwoc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Step channel
interface kwoc_in_if import kwoc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   op_code;
    logic                 read_move;
    logic [BASE_BITS-1:0] base;
    logic                 base_ok;

    modport source (output valid, output op_code, output read_move, output base,
                    output base_ok, input ready);
    modport sink   (input valid, input op_code, input read_move, input base,
                    input base_ok, output ready);
endinterface

// Result channel
interface kwoc_out_if import kwoc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      window_full;
    logic [INDEX_BITS-1:0]     window_code;
    logic [OUT_TOTAL_BITS-1:0] total_0;
    logic [OUT_TOTAL_BITS-1:0] total_1;
    logic [OUT_TOTAL_BITS-1:0] total_2;
    logic [OUT_TOTAL_BITS-1:0] total_3;
    logic [OUT_TOTAL_BITS-1:0] total_4;
    logic [OUT_TOTAL_BITS-1:0] total_5;
    logic [OUT_TOTAL_BITS-1:0] total_6;
    logic [OUT_TOTAL_BITS-1:0] total_7;
    logic [OUT_TOTAL_BITS-1:0] total_8;

    modport source (output valid, output window_full, output window_code,
                    output total_0, output total_1, output total_2, output total_3,
                    output total_4, output total_5, output total_6, output total_7,
                    output total_8, input ready);
    modport sink   (input valid, input window_full, input window_code,
                    input total_0, input total_1, input total_2, input total_3,
                    input total_4, input total_5, input total_6, input total_7,
                    input total_8, output ready);
endinterface

`default_nettype wire

FILE: rtl/kmer_window_op_counter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A step transfer fills the input register; then the window update and result register
// follow in one pass.
// Throughput: one step per cycle unless the result channel stalls; window rows, counters and totals update in parallel.
// Reset (synchronous, active low): empty window, zero totals, window length 6, both
// pipeline registers empty. A length write also empties the window and clears totals.
module kmer_window_op_counter_core import kwoc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [LEN_BITS-1:0] i_cfg_wr_data,
    kwoc_in_if.sink             i_in,
    kwoc_out_if.source          o_out
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [LEN_BITS-1:0]   r_len;
    logic                  r_in_valid;
    t_step                 r_in;
    logic [BASE_BITS-1:0]  r_base [MAX_K];
    logic [COUNT_BITS-1:0] r_cnt  [MAX_K][NUM_OPS];
    logic [TOTAL_BITS-1:0] r_tot  [NUM_OPS];
    logic [FILL_BITS-1:0]  r_fill;
    logic                  r_out_valid;
    t_result               r_out;

    logic [FILL_BITS-1:0]  eff_k;
    logic                  advance;
    logic                  do_drop;
    logic                  do_app;
    logic                  op_ok;
    logic [FILL_BITS-1:0]  fill_d;
    logic [FILL_BITS-1:0]  n_fill;
    logic [ROW_BITS-1:0]   newest;
    logic [BASE_BITS-1:0]  n_base [MAX_K];
    logic [COUNT_BITS-1:0] n_cnt  [MAX_K][NUM_OPS];
    logic [TOTAL_BITS-1:0] n_tot  [NUM_OPS];
    logic [INDEX_BITS-1:0] n_index;
    t_result               n_out;

    // Clamp the programmed length to 1..MAX_K
    always_comb begin
        if (r_len == '0) begin
            eff_k = FILL_BITS'(1);
        end else if (FILL_BITS'(r_len) > FILL_BITS'(MAX_K)) begin
            eff_k = FILL_BITS'(MAX_K);
        end else begin
            eff_k = FILL_BITS'(r_len);
        end
    end

    // Advance the input register into the result register when it has room
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Window control for the held step
    always_comb begin
        do_drop = r_in.read_move && (r_fill >= eff_k) && (r_fill != '0);
        fill_d  = r_fill - FILL_BITS'(do_drop);
        do_app  = r_in.read_move && r_in.base_ok && (fill_d < FILL_BITS'(MAX_K));
        n_fill  = fill_d + FILL_BITS'(do_app);
        op_ok   = (r_in.op_code < OP_BITS'(NUM_OPS)) && (n_fill != '0);
        newest  = ROW_BITS'(n_fill - FILL_BITS'(1));
    end

    // Shift, append and count in every row in parallel
    always_comb begin
        logic [BASE_BITS-1:0]  mid_base;
        logic [COUNT_BITS-1:0] mid_cnt;
        logic                  row_app;
        logic                  inc;
        logic                  tot_inc [NUM_OPS];
        for (int j = 0; j < NUM_OPS; j++) begin
            tot_inc[j] = 1'b0;
        end
        for (int i = 0; i < MAX_K; i++) begin
            row_app = do_app && (fill_d == FILL_BITS'(i));
            if (do_drop && (i < MAX_K - 1)) begin
                mid_base = r_base[(i + 1) % MAX_K];
            end else begin
                mid_base = r_base[i];
            end
            n_base[i] = row_app ? r_in.base : mid_base;
            for (int j = 0; j < NUM_OPS; j++) begin
                if (row_app) begin
                    mid_cnt = '0;
                end else if (do_drop && (i < MAX_K - 1)) begin
                    mid_cnt = r_cnt[(i + 1) % MAX_K][j];
                end else begin
                    mid_cnt = r_cnt[i][j];
                end
                inc = op_ok && (newest == ROW_BITS'(i)) &&
                      (r_in.op_code == OP_BITS'(j)) && (mid_cnt != COUNT_MAX);
                n_cnt[i][j] = mid_cnt + COUNT_BITS'(inc);
                tot_inc[j]  = tot_inc[j] | inc;
            end
        end
        // Take the dropped base off the totals and add this step's count
        for (int j = 0; j < NUM_OPS; j++) begin
            n_tot[j] = r_tot[j]
                     - (do_drop ? TOTAL_BITS'(r_cnt[0][j]) : TOTAL_BITS'(0))
                     + TOTAL_BITS'(tot_inc[j]);
        end
    end

    // Build the k-mer index from the updated window, oldest base first
    always_comb begin
        n_index = '0;
        for (int i = 0; i < MAX_K; i++) begin
            if (FILL_BITS'(i) < n_fill) begin
                n_index = {n_index[INDEX_BITS-BASE_BITS-1:0], n_base[i]};
            end
        end
    end

    always_comb begin
        n_out.window_full = (n_fill == eff_k);
        n_out.window_code = n_index;
        for (int j = 0; j < NUM_OPS; j++) begin
            n_out.total[j] = OUT_TOTAL_BITS'(n_tot[j]);
        end
    end

    // Control state, length register and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_RESET;
            r_fill      <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < NUM_OPS; j++) begin
                r_tot[j] <= '0;
            end
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_len  <= i_cfg_wr_data;
                r_fill <= '0;
                for (int j = 0; j < NUM_OPS; j++) begin
                    r_tot[j] <= '0;
                end
            end else if (advance) begin
                r_fill <= n_fill;
                for (int j = 0; j < NUM_OPS; j++) begin
                    r_tot[j] <= n_tot[j];
                end
            end
        end
    end

    // Payload: input step, window rows and result
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.op_code   <= i_in.op_code;
            r_in.read_move <= i_in.read_move;
            r_in.base      <= i_in.base;
            r_in.base_ok   <= i_in.base_ok;
        end
        if (advance) begin
            r_out <= n_out;
            for (int i = 0; i < MAX_K; i++) begin
                r_base[i] <= n_base[i];
                for (int j = 0; j < NUM_OPS; j++) begin
                    r_cnt[i][j] <= n_cnt[i][j];
                end
            end
        end
    end

    // Drive the result channel
    assign o_out.valid       = r_out_valid;
    assign o_out.window_full = r_out.window_full;
    assign o_out.window_code = r_out.window_code;
    assign o_out.total_0     = r_out.total[0];
    assign o_out.total_1     = r_out.total[1];
    assign o_out.total_2     = r_out.total[2];
    assign o_out.total_3     = r_out.total[3];
    assign o_out.total_4     = r_out.total[4];
    assign o_out.total_5     = r_out.total[5];
    assign o_out.total_6     = r_out.total[6];
    assign o_out.total_7     = r_out.total[7];
    assign o_out.total_8     = r_out.total[8];

`ifndef SYNTHESIS
    // The window never holds more bases than the effective length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_k)
        else $error("window fill exceeds length");

    // An append into a window that is not full grows it by one
    a_fill_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !i_cfg_wr_en && r_in.read_move && r_in.base_ok && (r_fill < eff_k))
        |=> (r_fill == $past(r_fill) + FILL_BITS'(1)))
        else $error("append did not grow the window");

    // A length write empties the window and clears the totals
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> ((r_fill == '0) && (r_tot[0] == '0) && (r_tot[NUM_OPS-1] == '0)))
        else $error("length write did not clear the window");

    // An empty result register never blocks a step transfer
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
